// ===== rtl/core/tia_pkg.sv =====
// Shared types, opcodes and status codes for the tetrad integer ALU.
package tia_pkg;

    localparam int DataWidth = 32;
    localparam int CountWidth = $clog2(DataWidth + 1);

    typedef logic [DataWidth-1:0] data_t;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_SUB    = 5'd1,
        CMD_MUL    = 5'd2,
        CMD_DIV    = 5'd3,
        CMD_MOD    = 5'd4,
        CMD_POW    = 5'd5,
        CMD_BITAND = 5'd6,
        CMD_LAND   = 5'd7,
        CMD_LOR    = 5'd8,
        CMD_LXOR   = 5'd9,
        CMD_NE     = 5'd10,
        CMD_LT     = 5'd11,
        CMD_GT     = 5'd12,
        CMD_LE     = 5'd13,
        CMD_GE     = 5'd14,
        CMD_EQ     = 5'd15,
        CMD_COPY   = 5'd16,
        CMD_NEG    = 5'd17,
        CMD_NOT    = 5'd18
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_NEGEXP = 2'd2
    } status_t;

    typedef struct packed {
        logic [4:0]           cmd;
        logic signed [DataWidth-1:0] left_value;
        logic signed [DataWidth-1:0] right_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] result_value;
        logic [1:0]                  status;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIVFIX,
        S_POW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_fix;
        logic pow_step;
    } ctl_t;

    typedef struct packed {
        logic kind_div;
        logic kind_pow;
        logic count_done;
    } sts_t;

endpackage

// ===== rtl/core/tetrad_integer_alu_unit.sv =====
// Top level of the tetrad integer ALU.
// One beat at a time: simple ops, divide by zero and negative exponents go from
// load through S_DIV to S_OUT; divide and remainder run the shift-subtract loop
// (one quotient bit per cycle), then a sign fix; power runs one step per
// significant exponent bit (up to 31). The result is held until taken; the next
// beat is accepted the cycle after.
module tetrad_integer_alu_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tia_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tia_pkg::out_beat_t out_data
);
    import tia_pkg::*;

    ctl_t ctl;
    sts_t sts;

    tia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    tia_datapath u_dp (
        .clk    (clk),
        .in_beat(in_data),
        .ctl    (ctl),
        .sts    (sts),
        .res    (out_data)
    );

endmodule

// ===== rtl/core/tia_datapath.sv =====
// Operand registers, shift-subtract divider, square-and-multiply and simple ops.
module tia_datapath (
    input  logic             clk,
    input  tia_pkg::in_beat_t in_beat,
    input  tia_pkg::ctl_t    ctl,
    output tia_pkg::sts_t    sts,
    output tia_pkg::out_beat_t res
);
    import tia_pkg::*;

    data_t a_reg, a_next;
    data_t b_reg, b_next;
    data_t r_reg, r_next;
    logic [1:0] st_reg, st_next;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic neg_q_reg, neg_q_next;
    logic neg_r_reg, neg_r_next;
    logic kdiv_reg, kdiv_next;
    logic kpow_reg, kpow_next;
    logic is_mod_reg, is_mod_next;

    data_t a_in, b_in, ma, mb, simple;
    logic az, bz, lt_ab, lt_ba;
    logic [DataWidth:0] rem_sh;
    logic [DataWidth:0] rem_sub;
    logic [2*DataWidth-1:0] prod_acc, prod_base;
    data_t quo, rem;

    function automatic data_t prod_acc_pow(input data_t x, input data_t y);
        logic [2*DataWidth-1:0] p;
        p = {{DataWidth{1'b0}}, x} * {{DataWidth{1'b0}}, y};
        return p[DataWidth-1:0];
    endfunction

    assign a_in = data_t'(in_beat.left_value);
    assign b_in = data_t'(in_beat.right_value);
    assign az = (a_in == '0);
    assign bz = (b_in == '0);
    assign lt_ab = $signed(a_in) < $signed(b_in);
    assign lt_ba = $signed(b_in) < $signed(a_in);
    assign ma = a_in[DataWidth-1] ? data_t'(-a_in) : a_in;
    assign mb = b_in[DataWidth-1] ? data_t'(-b_in) : b_in;

    always_comb
    begin
        prod_acc = '0;
        case (in_beat.cmd)
            CMD_MUL: prod_acc = {{DataWidth{1'b0}}, a_in} * {{DataWidth{1'b0}}, b_in};
            default: prod_acc = '0;
        endcase
        simple = '0;
        case (in_beat.cmd)
            CMD_ADD:    simple = a_in + b_in;
            CMD_SUB:    simple = a_in - b_in;
            CMD_MUL:    simple = prod_acc[DataWidth-1:0];
            CMD_BITAND: simple = a_in & b_in;
            CMD_LAND:   simple = data_t'(!az && !bz);
            CMD_LOR:    simple = data_t'(!az || !bz);
            CMD_LXOR:   simple = data_t'(az != bz);
            CMD_NE:     simple = data_t'(a_in != b_in);
            CMD_LT:     simple = data_t'(lt_ab);
            CMD_GT:     simple = data_t'(lt_ba);
            CMD_LE:     simple = data_t'(!lt_ba);
            CMD_GE:     simple = data_t'(!lt_ab);
            CMD_EQ:     simple = data_t'(a_in == b_in);
            CMD_COPY:   simple = a_in;
            CMD_NEG:    simple = data_t'(-a_in);
            CMD_NOT:    simple = data_t'(az);
            default:    simple = '0;
        endcase
    end

    // Divide: a_reg holds quotient bits shifting in, r_reg the partial remainder.
    assign rem_sh = {r_reg, a_reg[DataWidth-1]};
    assign rem_sub = rem_sh - {1'b0, b_reg};
    // Power: r_reg accumulator, a_reg base, b_reg exponent.
    assign prod_base = {{DataWidth{1'b0}}, a_reg} * {{DataWidth{1'b0}}, a_reg};
    assign quo = neg_q_reg ? data_t'(-a_reg) : a_reg;
    assign rem = neg_r_reg ? data_t'(-r_reg) : r_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        st_next = st_reg;
        cnt_next = cnt_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        kdiv_next = kdiv_reg;
        kpow_next = kpow_reg;
        is_mod_next = is_mod_reg;
        if (ctl.load)
        begin
            kdiv_next = 1'b0;
            kpow_next = 1'b0;
            st_next = ST_OK;
            r_next = simple;
            cnt_next = CountWidth'(DataWidth);
            is_mod_next = (in_beat.cmd == CMD_MOD);
            neg_q_next = a_in[DataWidth-1] ^ b_in[DataWidth-1];
            neg_r_next = a_in[DataWidth-1];
            if (in_beat.cmd == CMD_DIV || in_beat.cmd == CMD_MOD)
            begin
                if (bz)
                begin
                    st_next = ST_DIV0;
                    r_next = '0;
                end
                else
                begin
                    kdiv_next = 1'b1;
                    a_next = ma;
                    b_next = mb;
                    r_next = '0;
                end
            end
            else if (in_beat.cmd == CMD_POW)
            begin
                if (b_in[DataWidth-1])
                begin
                    st_next = ST_NEGEXP;
                    r_next = '0;
                end
                else
                begin
                    kpow_next = 1'b1;
                    a_next = a_in;
                    b_next = b_in;
                    r_next = data_t'(1);
                end
            end
        end
        else if (ctl.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!rem_sub[DataWidth])
            begin
                r_next = rem_sub[DataWidth-1:0];
                a_next = {a_reg[DataWidth-2:0], 1'b1};
            end
            else
            begin
                r_next = rem_sh[DataWidth-1:0];
                a_next = {a_reg[DataWidth-2:0], 1'b0};
            end
        end
        else if (ctl.div_fix)
        begin
            r_next = is_mod_reg ? rem : quo;
        end
        else if (ctl.pow_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (b_reg[0])
            begin
                r_next = prod_acc_pow(r_reg, a_reg);
            end
            a_next = prod_base[DataWidth-1:0];
            b_next = b_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        st_reg <= st_next;
        cnt_reg <= cnt_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        kdiv_reg <= kdiv_next;
        kpow_reg <= kpow_next;
        is_mod_reg <= is_mod_next;
    end

    assign sts.kind_div = kdiv_reg;
    assign sts.kind_pow = kpow_reg;
    assign sts.count_done = kpow_reg ? (b_reg == '0) : (cnt_reg == '0);
    assign res.result_value = r_reg;
    assign res.status = st_reg;

endmodule

// ===== rtl/core/tia_ctrl.sv =====
// Sequencer for load, divide and power iterations and result hand-off.
module tia_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  tia_pkg::sts_t sts,
    output tia_pkg::ctl_t ctl
);
    import tia_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.kind_pow)
                    state_next = S_POW;
                else if (!sts.kind_div)
                    state_next = S_OUT;
                else if (sts.count_done)
                    state_next = S_DIVFIX;
                else
                    ctl.div_step = 1'b1;
            end
            S_DIVFIX:
            begin
                ctl.div_fix = 1'b1;
                state_next = S_OUT;
            end
            S_POW:
            begin
                if (sts.count_done)
                    state_next = S_OUT;
                else
                    ctl.pow_step = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
